### rtl/core/cqws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqws_pkg
// Shared constants, types and the arctangent table of the quarter-wave sine.
// ----------------------------------------------------------------------------
package cqws_pkg;

    // number of micro-rotations, meaningful range 8..16
    localparam int ITERATIONS = 16;

    localparam int ANGLE_W     = 16;
    localparam int SINE_W      = 16;
    localparam int XY_W        = 32;
    localparam int Z_W         = 18;
    localparam int TABLE_IDX_W = 4;
    localparam int OUT_SHIFT   = 14;
    localparam int SAT_W       = XY_W - OUT_SHIFT;

    localparam logic signed [XY_W-1:0] START_X     = 32'sh11616E8E;
    localparam logic signed [XY_W-1:0] START_Y     = 32'sh22C2DD1C;
    localparam logic signed [Z_W-1:0]  START_ANGLE = 18'sh0B470;
    localparam logic [SINE_W-1:0]      SINE_MAX    = 16'hFFFF;

    // one item in flight through the rotation chain
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } vec_t;

    // arctangent of 2^-i in angle units
    function automatic logic signed [Z_W-1:0] step_angle(input logic [TABLE_IDX_W-1:0] idx);
        logic [15:0] a;
        case (idx)
            4'd0:    a = 16'h8000;
            4'd1:    a = 16'h4B90;
            4'd2:    a = 16'h27ED;
            4'd3:    a = 16'h1444;
            4'd4:    a = 16'h0A2C;
            4'd5:    a = 16'h0517;
            4'd6:    a = 16'h028C;
            4'd7:    a = 16'h0146;
            4'd8:    a = 16'h00A3;
            4'd9:    a = 16'h0051;
            4'd10:   a = 16'h0029;
            4'd11:   a = 16'h0014;
            4'd12:   a = 16'h000A;
            4'd13:   a = 16'h0005;
            4'd14:   a = 16'h0003;
            default: a = 16'h0001;
        endcase
        return $signed({{(Z_W - 16){1'b0}}, a});
    endfunction

endpackage
`default_nettype wire

### rtl/core/cqws_rot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqws_rot
// One CORDIC micro-rotation in rotation mode, steered by the residual sign.
// ----------------------------------------------------------------------------
module cqws_rot (
    input  wire cqws_pkg::vec_t                        vec_in,
    input  wire logic [cqws_pkg::TABLE_IDX_W-1:0]      shift,
    output cqws_pkg::vec_t                             vec_out
);

    logic signed [cqws_pkg::XY_W-1:0] dx;
    logic signed [cqws_pkg::XY_W-1:0] dy;
    logic signed [cqws_pkg::Z_W-1:0]  st;

    assign dx = vec_in.y >>> shift;
    assign dy = vec_in.x >>> shift;
    assign st = cqws_pkg::step_angle(shift);

    always_comb
    begin
        vec_out.zero = vec_in.zero;
        if (!vec_in.z[cqws_pkg::Z_W-1])
        begin
            vec_out.x = vec_in.x - dx;
            vec_out.y = vec_in.y + dy;
            vec_out.z = vec_in.z - st;
        end
        else
        begin
            vec_out.x = vec_in.x + dx;
            vec_out.y = vec_in.y - dy;
            vec_out.z = vec_in.z + st;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cordic_quarter_wave_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_quarter_wave_sine
// First-quadrant sine by a fully unrolled rotation-mode CORDIC pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: angle with in_valid / in_stall. 65536 angle units make a
//   quarter turn. A request is taken at a clock edge with in_valid high and
//   in_stall low.
//   Output channel: sine with out_valid / out_stall, sin(angle) * 65536,
//   saturated to 0..65535. A zero angle returns zero.
//   Path from acceptance to out_valid: the accepting edge loads the start
//   vector, each micro-rotation then registers into its own stage, and the
//   last stage registers through the saturation/output register.
//   Throughput: one request per clock while out_stall stays low, set by the
//   one-rotation-per-stage chain; each stage holds one add/subtract of x, y and the residual.
//   Stall: each stage holds its request when the stage after it is full and
//   not moving, so bubbles are squeezed out and nothing is lost or repeated.
//   in_stall rises only when every stage and the output register are full
//   while out_stall is high.
//   Reset: rst_n clears all valid bits at once; the pipeline is then empty
//   and ready.
// ----------------------------------------------------------------------------
module cordic_quarter_wave_sine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [cqws_pkg::ANGLE_W-1:0]    angle,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [cqws_pkg::SINE_W-1:0]          sine
);

    localparam int N = cqws_pkg::ITERATIONS;

    // stage 0 holds the start vector; stage k holds the vector after k rotations
    cqws_pkg::vec_t              stage_reg [N+1];
    cqws_pkg::vec_t              rot_out   [N];
    logic [N:0]                  valid_reg;
    logic [N+1:0]                ready;

    cqws_pkg::vec_t              load_next;
    logic [cqws_pkg::SINE_W-1:0] sine_next;
    logic signed [cqws_pkg::SAT_W-1:0] y_scaled;
    logic                        out_valid_reg;
    logic [cqws_pkg::SINE_W-1:0] sine_reg;

    // a stage may load when it is empty or its content moves on
    assign ready[N+1] = !out_valid_reg || !out_stall;
    genvar k;
    generate
        for (k = 0; k <= N; k++)
        begin : g_ready
            assign ready[k] = !valid_reg[k] || ready[k+1];
        end
    endgenerate

    assign in_stall = !ready[0];

    // build the start vector at atan(2) with the gain already divided out
    always_comb
    begin
        load_next.x    = cqws_pkg::START_X;
        load_next.y    = cqws_pkg::START_Y;
        load_next.z    = $signed({{(cqws_pkg::Z_W - cqws_pkg::ANGLE_W){1'b0}}, angle})
                         - cqws_pkg::START_ANGLE;
        load_next.zero = (angle == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ready[0])
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            stage_reg[0] <= load_next;
        end
    end

    // one micro-rotation between each pair of stages
    generate
        for (k = 0; k < N; k++)
        begin : g_rot
            cqws_rot u_rot (
                .vec_in  (stage_reg[k]),
                .shift   (cqws_pkg::TABLE_IDX_W'(k)),
                .vec_out (rot_out[k])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (ready[k+1])
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[k+1] && valid_reg[k])
                begin
                    stage_reg[k+1] <= rot_out[k];
                end
            end
        end
    endgenerate

    // scale y down and clamp into the unsigned result range
    assign y_scaled = cqws_pkg::SAT_W'(stage_reg[N].y >>> cqws_pkg::OUT_SHIFT);

    always_comb
    begin
        if (stage_reg[N].zero || y_scaled[cqws_pkg::SAT_W-1])
        begin
            sine_next = '0;
        end
        else if (y_scaled > $signed({{(cqws_pkg::SAT_W - cqws_pkg::SINE_W){1'b0}},
                                     cqws_pkg::SINE_MAX}))
        begin
            sine_next = cqws_pkg::SINE_MAX;
        end
        else
        begin
            sine_next = cqws_pkg::SINE_W'(y_scaled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready[N+1])
        begin
            out_valid_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[N+1] && valid_reg[N])
        begin
            sine_reg <= sine_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = sine_reg;

    // input backpressure only when the whole chain is full behind a stalled output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&valid_reg)))
        else $error("input stalled while the pipeline has room");

    // a finished rotation reaches the output when the output is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[N] && !(out_valid && out_stall)) |=> out_valid)
        else $error("finished request did not reach the output");

    // drop out_valid when the output is taken and nothing follows
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid_reg[N]) |=> !out_valid)
        else $error("request repeated at the output");

endmodule
`default_nettype wire
